// ===== sv/lpg_pkg.sv =====
// Shared types and constants for the line pixel generator.
package lpg_pkg;

  localparam int COORD_BITS = 12;
  localparam int COLOR_W    = 32;
  localparam int CNT_W      = COORD_BITS + 1;
  localparam int SUM_W      = CNT_W + 1;
  localparam int RAD_W      = 2 * COORD_BITS + 2;

  localparam logic ACT_LOAD    = 1'b0;
  localparam logic ACT_ADVANCE = 1'b1;

  typedef logic [COORD_BITS-1:0] coord_t;
  typedef logic [CNT_W-1:0]      count_t;

  typedef enum logic [1:0] {
    R_IDLE,
    R_SQX,
    R_SQY,
    R_ROOT
  } root_state_t;

  typedef struct packed {
    logic load;
    logic advance;
  } step_ctl_t;

  typedef struct packed {
    coord_t             x;
    coord_t             y;
    logic [COLOR_W-1:0] value;
    logic               last;
  } pixel_t;

endpackage

// ===== sv/lpg_root_unit.sv =====
// Shared multiply and digit-by-digit square root unit that computes the step count.
module lpg_root_unit (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  input  lpg_pkg::coord_t     span_x,
  input  lpg_pkg::coord_t     span_y,
  output logic                busy,
  output logic                done,
  output lpg_pkg::count_t     root
);
  import lpg_pkg::*;

  root_state_t                state_r, state_nxt;
  logic [RAD_W-1:0]           rad_r, rad_nxt;
  logic [RAD_W-1:0]           root_r, root_nxt;
  logic [RAD_W-1:0]           bit_r, bit_nxt;
  logic [RAD_W-1:0]           trial;
  coord_t                     mul_op;
  logic [2*COORD_BITS-1:0]    prod;

  assign mul_op = (state_r == R_SQX) ? span_x : span_y;
  assign prod   = (2*COORD_BITS)'(mul_op) * (2*COORD_BITS)'(mul_op);
  assign trial  = root_r + bit_r;

  always_comb begin
    state_nxt = state_r;
    rad_nxt   = rad_r;
    root_nxt  = root_r;
    bit_nxt   = bit_r;
    done      = 1'b0;
    unique case (state_r)
      R_IDLE: begin
        if (start) begin
          state_nxt = R_SQX;
        end
      end
      R_SQX: begin
        rad_nxt   = RAD_W'(prod);
        state_nxt = R_SQY;
      end
      R_SQY: begin
        rad_nxt   = rad_r + RAD_W'(prod);
        root_nxt  = '0;
        bit_nxt   = RAD_W'(1) << (RAD_W - 2);
        state_nxt = R_ROOT;
      end
      R_ROOT: begin
        if (rad_r >= trial) begin
          rad_nxt  = rad_r - trial;
          root_nxt = (root_r >> 1) + bit_r;
        end else begin
          root_nxt = root_r >> 1;
        end
        bit_nxt = bit_r >> 2;
        if (bit_r[0]) begin
          done      = 1'b1;
          state_nxt = R_IDLE;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= R_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rad_r  <= rad_nxt;
    root_r <= root_nxt;
    bit_r  <= bit_nxt;
  end

  assign busy = (state_r != R_IDLE);
  assign root = root_nxt[CNT_W-1:0];

endmodule

// ===== sv/lpg_stepper.sv =====
// Line state registers and the per-pixel remainder stepping datapath.
module lpg_stepper (
  input  logic                         clk,
  input  logic                         rst_n,
  input  lpg_pkg::step_ctl_t           ctl,
  input  lpg_pkg::coord_t              start_x,
  input  lpg_pkg::coord_t              start_y,
  input  lpg_pkg::coord_t              end_x,
  input  lpg_pkg::coord_t              end_y,
  input  logic [lpg_pkg::COLOR_W-1:0]  color,
  input  logic                         count_we,
  input  lpg_pkg::count_t              count_in,
  output lpg_pkg::coord_t              span_x,
  output lpg_pkg::coord_t              span_y,
  output logic                         has_pix,
  output lpg_pkg::pixel_t              pix
);
  import lpg_pkg::*;

  coord_t             origin_x_r, origin_x_nxt, origin_y_r, origin_y_nxt;
  logic               neg_x_r, neg_x_nxt, neg_y_r, neg_y_nxt;
  coord_t             span_x_r, span_x_nxt, span_y_r, span_y_nxt;
  count_t             count_r, count_nxt, index_r, index_nxt;
  count_t             rem_x_r, rem_x_nxt, rem_y_r, rem_y_nxt;
  coord_t             offset_x_r, offset_x_nxt, offset_y_r, offset_y_nxt;
  logic [COLOR_W-1:0] color_r, color_nxt;
  logic               in_neg_x, in_neg_y;
  logic [SUM_W-1:0]   sum_x, sum_y;

  assign in_neg_x = (end_x < start_x);
  assign in_neg_y = (end_y < start_y);
  assign sum_x    = SUM_W'(rem_x_r) + SUM_W'(span_x_r);
  assign sum_y    = SUM_W'(rem_y_r) + SUM_W'(span_y_r);

  assign has_pix   = (index_r < count_r);
  assign pix.x     = neg_x_r ? (origin_x_r - offset_x_r) : (origin_x_r + offset_x_r);
  assign pix.y     = neg_y_r ? (origin_y_r - offset_y_r) : (origin_y_r + offset_y_r);
  assign pix.value = color_r;
  assign pix.last  = ((index_r + CNT_W'(1)) == count_r);

  always_comb begin
    origin_x_nxt = origin_x_r;
    origin_y_nxt = origin_y_r;
    neg_x_nxt    = neg_x_r;
    neg_y_nxt    = neg_y_r;
    span_x_nxt   = span_x_r;
    span_y_nxt   = span_y_r;
    count_nxt    = count_r;
    index_nxt    = index_r;
    rem_x_nxt    = rem_x_r;
    rem_y_nxt    = rem_y_r;
    offset_x_nxt = offset_x_r;
    offset_y_nxt = offset_y_r;
    color_nxt    = color_r;
    if (ctl.load) begin
      origin_x_nxt = start_x;
      origin_y_nxt = start_y;
      neg_x_nxt    = in_neg_x;
      neg_y_nxt    = in_neg_y;
      span_x_nxt   = in_neg_x ? (start_x - end_x) : (end_x - start_x);
      span_y_nxt   = in_neg_y ? (start_y - end_y) : (end_y - start_y);
      count_nxt    = '0;
      index_nxt    = '0;
      rem_x_nxt    = '0;
      rem_y_nxt    = '0;
      offset_x_nxt = '0;
      offset_y_nxt = '0;
      color_nxt    = color;
    end else if (ctl.advance && has_pix) begin
      index_nxt = index_r + CNT_W'(1);
      if (sum_x >= SUM_W'(count_r)) begin
        rem_x_nxt    = CNT_W'(sum_x - SUM_W'(count_r));
        offset_x_nxt = offset_x_r + COORD_BITS'(1);
      end else begin
        rem_x_nxt = CNT_W'(sum_x);
      end
      if (sum_y >= SUM_W'(count_r)) begin
        rem_y_nxt    = CNT_W'(sum_y - SUM_W'(count_r));
        offset_y_nxt = offset_y_r + COORD_BITS'(1);
      end else begin
        rem_y_nxt = CNT_W'(sum_y);
      end
    end else if (count_we) begin
      count_nxt = count_in;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      origin_x_r <= '0;
      origin_y_r <= '0;
      neg_x_r    <= 1'b0;
      neg_y_r    <= 1'b0;
      span_x_r   <= '0;
      span_y_r   <= '0;
      count_r    <= '0;
      index_r    <= '0;
      rem_x_r    <= '0;
      rem_y_r    <= '0;
      offset_x_r <= '0;
      offset_y_r <= '0;
      color_r    <= '0;
    end else begin
      origin_x_r <= origin_x_nxt;
      origin_y_r <= origin_y_nxt;
      neg_x_r    <= neg_x_nxt;
      neg_y_r    <= neg_y_nxt;
      span_x_r   <= span_x_nxt;
      span_y_r   <= span_y_nxt;
      count_r    <= count_nxt;
      index_r    <= index_nxt;
      rem_x_r    <= rem_x_nxt;
      rem_y_r    <= rem_y_nxt;
      offset_x_r <= offset_x_nxt;
      offset_y_r <= offset_y_nxt;
      color_r    <= color_nxt;
    end
  end

  assign span_x = span_x_r;
  assign span_y = span_y_r;

endmodule

// ===== sv/line_pixel_generator_core.sv =====
// Top level of the line pixel generator: handshakes, output register and checks.
//
// Usage: each input transaction carries in_action. A load transaction (action 0)
// latches both endpoints and the color and replaces any line in progress; it
// gives no output. An advance transaction (action 1) gives one pixel on the
// output channel, or nothing when the line is empty or already finished.
// The last pixel of a line has out_last set; the second endpoint is not drawn.
// A load takes the spans, squares them in turn through the shared multiplier
// for the squared length, then runs the two-bits-per-cycle square root that
// yields the step count; in_ready is low meanwhile. An advance is one
// add-and-compare per axis, so pixels come out one per cycle while out_ready
// stays high, each in the cycle after its transaction is accepted.
// The output register lets a new transaction be accepted in the same cycle in
// which the pending pixel is taken; while the receiver stalls with a pixel
// pending, in_ready stays low. Reset clears the line state, so advances after
// reset give no pixel until a line is loaded.
module line_pixel_generator_core (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic                         in_action,
  input  lpg_pkg::coord_t              in_start_x,
  input  lpg_pkg::coord_t              in_start_y,
  input  lpg_pkg::coord_t              in_end_x,
  input  lpg_pkg::coord_t              in_end_y,
  input  logic [lpg_pkg::COLOR_W-1:0]  in_color,
  output logic                         out_valid,
  input  logic                         out_ready,
  output lpg_pkg::coord_t              out_pixel_x,
  output lpg_pkg::coord_t              out_pixel_y,
  output logic [lpg_pkg::COLOR_W-1:0]  out_pixel_value,
  output logic                         out_last
);
  import lpg_pkg::*;

  step_ctl_t ctl;
  logic      in_fire;
  logic      root_busy, root_done;
  count_t    root_val;
  coord_t    span_x, span_y;
  logic      has_pix;
  pixel_t    pix;
  pixel_t    out_pix_r;
  logic      out_valid_r, out_valid_nxt;

  assign in_ready    = !root_busy && (!out_valid_r || out_ready);
  assign in_fire     = in_valid && in_ready;
  assign ctl.load    = in_fire && (in_action == ACT_LOAD);
  assign ctl.advance = in_fire && (in_action == ACT_ADVANCE);

  lpg_stepper u_stepper (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctl      (ctl),
    .start_x  (in_start_x),
    .start_y  (in_start_y),
    .end_x    (in_end_x),
    .end_y    (in_end_y),
    .color    (in_color),
    .count_we (root_done),
    .count_in (root_val),
    .span_x   (span_x),
    .span_y   (span_y),
    .has_pix  (has_pix),
    .pix      (pix)
  );

  lpg_root_unit u_root (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (ctl.load),
    .span_x (span_x),
    .span_y (span_y),
    .busy   (root_busy),
    .done   (root_done),
    .root   (root_val)
  );

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (ctl.advance && has_pix) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.advance && has_pix) begin
      out_pix_r <= pix;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_pixel_x     = out_pix_r.x;
  assign out_pixel_y     = out_pix_r.y;
  assign out_pixel_value = out_pix_r.value;
  assign out_last        = out_pix_r.last;

  a_root_after_load: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(root_busy) |-> $past(ctl.load))
    else $error("Square root unit started without a load transaction.");

  a_pixel_from_advance: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(ctl.advance && has_pix))
    else $error("Output became valid without an advance transaction.");

  a_count_covers_span: assert property (@(posedge clk) disable iff (!rst_n)
    root_done |-> ((root_val >= CNT_W'(span_x)) && (root_val >= CNT_W'(span_y))))
    else $error("Step count is below an axis span.");

  a_last_ends_line: assert property (@(posedge clk) disable iff (!rst_n)
    (ctl.advance && has_pix && pix.last) |=> !has_pix)
    else $error("Line continued after its last pixel.");

endmodule

// ===== test/tb_top.sv =====
// Self-checking testbench for line_pixel_generator_core: directed table, then random lines.
`timescale 1ns / 1ps

module tb_top;
  import lpg_pkg::*;

  localparam int N_DIR        = 25;
  localparam int RAND_ITEMS   = 500;
  localparam int HOLD_CYCLES  = 250;
  localparam int DRAIN_CYCLES = 40;
  localparam int LIMIT_CYCLES = 200000;
  localparam pixel_t NO_PIX   = '0;

  typedef struct {
    logic               act;
    coord_t             sx;
    coord_t             sy;
    coord_t             ex;
    coord_t             ey;
    logic [COLOR_W-1:0] col;
    bit                 typed;
    bit                 emit;
    pixel_t             want;
  } row_t;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic               in_action = ACT_LOAD;
  coord_t             in_start_x = '0;
  coord_t             in_start_y = '0;
  coord_t             in_end_x = '0;
  coord_t             in_end_y = '0;
  logic [COLOR_W-1:0] in_color = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  coord_t             out_pixel_x;
  coord_t             out_pixel_y;
  logic [COLOR_W-1:0] out_pixel_value;
  logic               out_last;

  // Line state of the predictor.
  coord_t             org_x = '0, org_y = '0;
  bit                 neg_x = 0, neg_y = 0;
  coord_t             span_x = '0, span_y = '0;
  count_t             n_steps = '0, step_idx = '0;
  count_t             rem_x = '0, rem_y = '0;
  coord_t             off_x = '0, off_y = '0;
  logic [COLOR_W-1:0] line_color = '0;

  pixel_t pending_pixels[$];
  bit     quiet = 1'b0;
  int     hold_asks = 0;
  int     err_count = 0;
  int     sent_count = 0;
  int     loads_sent = 0;
  int     pixels_seen = 0;
  int     ends_seen = 0;
  int     cycle_count = 0;

  row_t dir_rows [N_DIR] = '{
    '{ACT_ADVANCE, 12'd0, 12'd0, 12'd0, 12'd0, 32'h0, 1'b1, 1'b0, NO_PIX},
    '{ACT_LOAD, 12'd0, 12'd0, 12'd3, 12'd4, 32'hFFFF_FFFF, 1'b1, 1'b0, NO_PIX},
    '{ACT_ADVANCE, 12'd0, 12'd0, 12'd0, 12'd0, 32'h0, 1'b1, 1'b1,
      '{12'd0, 12'd0, 32'hFFFF_FFFF, 1'b0}},
    '{ACT_ADVANCE, 12'd0, 12'd0, 12'd0, 12'd0, 32'h0, 1'b0, 1'b0, NO_PIX},
    '{ACT_ADVANCE, 12'd4095, 12'd4095, 12'd4095, 12'd4095, 32'hFFFF_FFFF,
      1'b0, 1'b0, NO_PIX},
    '{ACT_ADVANCE, 12'd0, 12'd0, 12'd0, 12'd0, 32'h0, 1'b0, 1'b0, NO_PIX},
    '{ACT_ADVANCE, 12'd0, 12'd0, 12'd0, 12'd0, 32'h0, 1'b0, 1'b0, NO_PIX},
    '{ACT_ADVANCE, 12'd0, 12'd0, 12'd0, 12'd0, 32'h0, 1'b1, 1'b0, NO_PIX},
    '{ACT_LOAD, 12'd4095, 12'd4095, 12'd0, 12'd0, 32'h0, 1'b1, 1'b0, NO_PIX},
    '{ACT_ADVANCE, 12'd0, 12'd0, 12'd0, 12'd0, 32'h0, 1'b1, 1'b1,
      '{12'd4095, 12'd4095, 32'h0, 1'b0}},
    '{ACT_ADVANCE, 12'd0, 12'd0, 12'd0, 12'd0, 32'h0, 1'b0, 1'b0, NO_PIX},
    '{ACT_ADVANCE, 12'd0, 12'd0, 12'd0, 12'd0, 32'h0, 1'b0, 1'b0, NO_PIX},
    '{ACT_LOAD, 12'd0, 12'd4095, 12'd4095, 12'd0, 32'hA5A5_A5A5, 1'b1, 1'b0, NO_PIX},
    '{ACT_ADVANCE, 12'd0, 12'd0, 12'd0, 12'd0, 32'h0, 1'b1, 1'b1,
      '{12'd0, 12'd4095, 32'hA5A5_A5A5, 1'b0}},
    '{ACT_ADVANCE, 12'd0, 12'd0, 12'd0, 12'd0, 32'h0, 1'b0, 1'b0, NO_PIX},
    '{ACT_LOAD, 12'd0, 12'd0, 12'd1, 12'd0, 32'h5A5A_5A5A, 1'b1, 1'b0, NO_PIX},
    '{ACT_ADVANCE, 12'd0, 12'd0, 12'd0, 12'd0, 32'h0, 1'b1, 1'b1,
      '{12'd0, 12'd0, 32'h5A5A_5A5A, 1'b1}},
    '{ACT_ADVANCE, 12'd0, 12'd0, 12'd0, 12'd0, 32'h0, 1'b1, 1'b0, NO_PIX},
    '{ACT_LOAD, 12'd4095, 12'd4095, 12'd4095, 12'd4095, 32'h1234_5678,
      1'b1, 1'b0, NO_PIX},
    '{ACT_ADVANCE, 12'd0, 12'd0, 12'd0, 12'd0, 32'h0, 1'b1, 1'b0, NO_PIX},
    '{ACT_LOAD, 12'd4095, 12'd0, 12'd0, 12'd0, 32'hFFFF_FFFF, 1'b1, 1'b0, NO_PIX},
    '{ACT_ADVANCE, 12'd0, 12'd0, 12'd0, 12'd0, 32'h0, 1'b1, 1'b1,
      '{12'd4095, 12'd0, 32'hFFFF_FFFF, 1'b0}},
    '{ACT_ADVANCE, 12'd0, 12'd0, 12'd0, 12'd0, 32'h0, 1'b0, 1'b0, NO_PIX},
    '{ACT_LOAD, 12'd2048, 12'd2048, 12'd2048, 12'd2049, 32'h0, 1'b1, 1'b0, NO_PIX},
    '{ACT_ADVANCE, 12'd0, 12'd0, 12'd0, 12'd0, 32'h0, 1'b1, 1'b1,
      '{12'd2048, 12'd2048, 32'h0, 1'b1}}
  };

  line_pixel_generator_core DUT (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_action       (in_action),
    .in_start_x      (in_start_x),
    .in_start_y      (in_start_y),
    .in_end_x        (in_end_x),
    .in_end_y        (in_end_y),
    .in_color        (in_color),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_pixel_x     (out_pixel_x),
    .out_pixel_y     (out_pixel_y),
    .out_pixel_value (out_pixel_value),
    .out_last        (out_last)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  function automatic void raster_step(input logic act, input coord_t sx, input coord_t sy,
                                      input coord_t ex, input coord_t ey,
                                      input logic [COLOR_W-1:0] col,
                                      output bit emits, output pixel_t px);
    logic [63:0] len_sq;
    logic [63:0] root;
    logic [63:0] trial;
    int          rx;
    int          ry;
    emits = 0;
    px = '0;
    if (act == ACT_LOAD) begin
      org_x = sx;
      org_y = sy;
      neg_x = ex < sx;
      neg_y = ey < sy;
      span_x = neg_x ? sx - ex : ex - sx;
      span_y = neg_y ? sy - ey : ey - sy;
      len_sq = 64'(span_x) * 64'(span_x) + 64'(span_y) * 64'(span_y);
      root = 0;
      for (int b = CNT_W - 1; b >= 0; b--) begin
        trial = root | (64'd1 << b);
        if (trial * trial <= len_sq) root = trial;
      end
      n_steps = count_t'(root);
      step_idx = '0;
      rem_x = '0;
      rem_y = '0;
      off_x = '0;
      off_y = '0;
      line_color = col;
    end else if (step_idx < n_steps) begin
      emits = 1;
      px.x = neg_x ? org_x - off_x : org_x + off_x;
      px.y = neg_y ? org_y - off_y : org_y + off_y;
      px.value = line_color;
      px.last = (step_idx + CNT_W'(1)) == n_steps;
      step_idx = step_idx + CNT_W'(1);
      rx = int'(rem_x) + int'(span_x);
      if (rx >= int'(n_steps)) begin
        rx -= int'(n_steps);
        off_x = off_x + COORD_BITS'(1);
      end
      rem_x = count_t'(rx);
      ry = int'(rem_y) + int'(span_y);
      if (ry >= int'(n_steps)) begin
        ry -= int'(n_steps);
        off_y = off_y + COORD_BITS'(1);
      end
      rem_y = count_t'(ry);
    end
  endfunction

  task automatic note_mismatch(input string msg);
    if (err_count < 30) $display("[%0t] %s", $time, msg);
    err_count++;
  endtask

  task automatic send_item(input logic act, input coord_t sx, input coord_t sy,
                           input coord_t ex, input coord_t ey, input logic [COLOR_W-1:0] col,
                           input bit typed, input bit t_emit, input pixel_t t_px);
    bit     emits;
    pixel_t px;
    if (!quiet) begin
      while ($urandom_range(99) < 36) begin
        in_valid <= 1'b0;
        @(posedge clk);
      end
    end
    in_valid <= 1'b1;
    in_action <= act;
    in_start_x <= sx;
    in_start_y <= sy;
    in_end_x <= ex;
    in_end_y <= ey;
    in_color <= col;
    do @(posedge clk); while (!in_ready);
    raster_step(act, sx, sy, ex, ey, col, emits, px);
    sent_count++;
    if (act == ACT_LOAD) loads_sent++;
    if (typed) begin
      emits = t_emit;
      px = t_px;
    end
    if (emits) pending_pixels.push_back(px);
  endtask

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= LIMIT_CYCLES) begin
      $display("Timeout with %0d pixels outstanding.", pending_pixels.size());
      $display("line_pixel_generator_core: mismatch");
      $finish;
    end
  end

  always @(posedge clk) begin
    pixel_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_pixels.size() == 0) begin
        note_mismatch($sformatf("unexpected pixel (%0d,%0d)", out_pixel_x, out_pixel_y));
      end else begin
        want = pending_pixels.pop_front();
        if (out_pixel_x !== want.x)
          note_mismatch($sformatf("pixel_x %0d, want %0d", out_pixel_x, want.x));
        if (out_pixel_y !== want.y)
          note_mismatch($sformatf("pixel_y %0d, want %0d", out_pixel_y, want.y));
        if (out_pixel_value !== want.value)
          note_mismatch($sformatf("pixel_value %h, want %h", out_pixel_value, want.value));
        if (out_last !== want.last)
          note_mismatch($sformatf("last %b, want %b", out_last, want.last));
        pixels_seen++;
        if (want.last) ends_seen++;
      end
    end
  end

  initial begin
    int hold_left;
    int hold_seen;
    hold_left = 0;
    hold_seen = 0;
    forever begin
      @(posedge clk);
      if (hold_asks != hold_seen) begin
        hold_seen = hold_asks;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        out_ready <= 1'b0;
        hold_left--;
      end else begin
        out_ready <= quiet || ($urandom_range(99) >= 36);
      end
    end
  end

  initial begin
    int sx, sy, ex, ey, d, nadv, kind;
    bit pressed;
    pressed = 0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    foreach (dir_rows[i]) begin
      send_item(dir_rows[i].act, dir_rows[i].sx, dir_rows[i].sy, dir_rows[i].ex,
                dir_rows[i].ey, dir_rows[i].col, dir_rows[i].typed, dir_rows[i].emit,
                dir_rows[i].want);
    end
    quiet <= 1'b1;
    while (sent_count < N_DIR + RAND_ITEMS) begin
      if (quiet && sent_count >= N_DIR + 120) quiet <= 1'b0;
      if (!pressed && sent_count >= N_DIR + 300) begin
        pressed = 1;
        send_item(ACT_LOAD, 12'd0, 12'd0, 12'd4095, 12'd4095, $urandom, 0, 0, NO_PIX);
        hold_asks <= hold_asks + 1;
        repeat (60) begin
          send_item(ACT_ADVANCE, coord_t'($urandom), coord_t'($urandom),
                    coord_t'($urandom), coord_t'($urandom), $urandom, 0, 0, NO_PIX);
        end
      end
      kind = $urandom_range(99);
      if (kind < 85) begin
        sx = $urandom_range(4095);
        sy = $urandom_range(4095);
        if ($urandom_range(9) == 0) begin
          ex = $urandom_range(4095);
          ey = $urandom_range(4095);
        end else begin
          d = $urandom_range(12);
          if ($urandom_range(1)) ex = (sx >= d) ? sx - d : sx + d;
          else ex = (sx + d <= 4095) ? sx + d : sx - d;
          d = $urandom_range(12);
          if ($urandom_range(1)) ey = (sy >= d) ? sy - d : sy + d;
          else ey = (sy + d <= 4095) ? sy + d : sy - d;
        end
        send_item(ACT_LOAD, coord_t'(sx), coord_t'(sy), coord_t'(ex), coord_t'(ey),
                  $urandom, 0, 0, NO_PIX);
        nadv = (n_steps <= 24) ? int'(n_steps) + int'($urandom_range(2))
                               : int'($urandom_range(1, 24));
        repeat (nadv) begin
          send_item(ACT_ADVANCE, coord_t'($urandom), coord_t'($urandom),
                    coord_t'($urandom), coord_t'($urandom), $urandom, 0, 0, NO_PIX);
        end
      end else if (kind < 93) begin
        send_item(ACT_ADVANCE, coord_t'($urandom), coord_t'($urandom),
                  coord_t'($urandom), coord_t'($urandom), $urandom, 0, 0, NO_PIX);
      end else begin
        send_item(ACT_LOAD, coord_t'($urandom), coord_t'($urandom),
                  coord_t'($urandom), coord_t'($urandom), $urandom, 0, 0, NO_PIX);
      end
    end
    in_valid <= 1'b0;
    while (pending_pixels.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("Sent %0d transactions including %0d line loads over %0d cycles.",
             sent_count, loads_sent, cycle_count);
    $display("Checked %0d pixels, %0d of them closing a line; %0d errors.",
             pixels_seen, ends_seen, err_count);
    if (err_count == 0) begin
      $display("line_pixel_generator_core: match");
    end else begin
      $display("line_pixel_generator_core: mismatch");
    end
    $finish;
  end

endmodule
